[rtl/ctvs_pkg.sv]
package ctvs_pkg;

  localparam int unsigned ElemW  = 16;
  localparam int unsigned AccW   = 48;
  localparam int unsigned ScoreW = 16;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    CFG_DIM  = 1'b0,
    CFG_TOPK = 1'b1
  } cfg_idx_e;

  // Top level control states.
  typedef enum logic [2:0] {
    S_IDLE, S_NORM, S_QNORM, S_DOT, S_DIV, S_DRAIN, S_OUT, S_EMPTY
  } state_e;

  // Square-root/divide unit states.
  typedef enum logic [2:0] {
    D_IDLE, D_SQ1, D_SQ2, D_MUL, D_DIV, D_FIN
  } dstate_e;

  typedef struct packed {
    logic [1:0]        op;
    logic signed [15:0] value;
    logic              last_of_vector;
  } in_word_t;

  typedef struct packed {
    logic [5:0]         entry_index;
    logic signed [15:0] score;
    logic               last_result;
    logic               status;
  } out_word_t;

  // Candidate traveling along the ranking chain.
  typedef struct packed {
    logic               vld;
    logic [11:0]        idx;
    logic signed [15:0] score;
  } cand_t;

endpackage

[rtl/ctvs_div.sv]
// Sequential unit: isqrt(qn), isqrt(en), product, then restoring divide.
module ctvs_div import ctvs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [AccW-1:0]          qn_i,
  input  logic [AccW-1:0]          en_i,
  input  logic [AccW-1:0]          dot_i,
  input  logic                     zero_i,
  output logic                     done_o,
  output logic signed [ScoreW-1:0] score_o
);

  dstate_e st_q, st_d;
  logic [AccW-1:0] n_q, n_d, r_q, r_d, bit_q, bit_d;
  logic [23:0]     sa_q, sa_d;
  logic [AccW-1:0] den_q, den_d;
  logic [AccW+15:0] num_q, num_d;
  logic [AccW+15:0] rem_q, rem_d;
  logic [AccW+15:0] quo_q, quo_d;
  logic [6:0]      cnt_q, cnt_d;
  logic            neg_q, neg_d, zero_q, zero_d;
  logic signed [ScoreW-1:0] sc_q, sc_d;
  logic            done_q, done_d;
  logic [AccW-1:0] mag;
  logic [AccW+15:0] rs;

  assign mag = dot_i[AccW-1] ? (~dot_i + 1'b1) : dot_i;
  assign done_o  = done_q;
  assign score_o = sc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= D_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; r_q <= r_d; bit_q <= bit_d; sa_q <= sa_d; den_q <= den_d;
    num_q <= num_d; rem_q <= rem_d; quo_q <= quo_d; cnt_q <= cnt_d;
    neg_q <= neg_d; zero_q <= zero_d; sc_q <= sc_d;
  end

  always_comb begin
    st_d = st_q; n_d = n_q; r_d = r_q; bit_d = bit_q; sa_d = sa_q;
    den_d = den_q; num_d = num_q; rem_d = rem_q; quo_d = quo_q;
    cnt_d = cnt_q; neg_d = neg_q; zero_d = zero_q; sc_d = sc_q;
    done_d = 1'b0;
    rs = '0;
    case (st_q)
      D_IDLE: begin
        if (start_i) begin
          zero_d = zero_i || (qn_i == '0) || (en_i == '0);
          neg_d  = dot_i[AccW-1];
          num_d  = {1'b0, mag, 15'd0};
          n_d    = qn_i;
          r_d    = '0;
          bit_d  = {2'b01, {(AccW-2){1'b0}}};
          cnt_d  = 7'd0;
          st_d   = D_SQ1;
        end
      end
      D_SQ1, D_SQ2: begin
        if (bit_q != '0) begin
          if (n_q >= r_q + bit_q) begin
            n_d = n_q - (r_q + bit_q);
            r_d = (r_q >> 1) + bit_q;
          end else begin
            r_d = r_q >> 1;
          end
          bit_d = bit_q >> 2;
        end else if (st_q == D_SQ1) begin
          sa_d  = r_q[23:0];
          n_d   = en_i;
          r_d   = '0;
          bit_d = {2'b01, {(AccW-2){1'b0}}};
          st_d  = D_SQ2;
        end else begin
          st_d = D_MUL;
        end
      end
      D_MUL: begin
        den_d = {24'd0, sa_q} * {24'd0, r_q[23:0]};
        rem_d = '0;
        quo_d = '0;
        cnt_d = 7'd0;
        st_d  = D_DIV;
      end
      D_DIV: begin
        rs = {rem_q[AccW+14:0], num_q[AccW+15]};
        num_d = num_q << 1;
        if (rs >= {16'd0, den_q}) begin
          rem_d = rs - {16'd0, den_q};
          quo_d = {quo_q[AccW+14:0], 1'b1};
        end else begin
          rem_d = rs;
          quo_d = {quo_q[AccW+14:0], 1'b0};
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(AccW + 15)) st_d = D_FIN;
      end
      D_FIN: begin
        if (zero_q || den_q == '0) sc_d = '0;
        else if (neg_q) sc_d = (quo_q >= 64'd32768) ? 16'sh8000 : -$signed(quo_q[15:0]);
        else sc_d = (quo_q >= 64'd32767) ? 16'sh7fff : $signed(quo_q[15:0]);
        done_d = 1'b1;
        st_d = D_IDLE;
      end
      default: st_d = D_IDLE;
    endcase
  end

endmodule

[rtl/ctvs_cell.sv]
// One ranking cell: keeps the better candidate, hands the other on next step.
module ctvs_cell import ctvs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  clr_i,
  input  logic  shift_i,
  input  cand_t cand_i,
  output cand_t cand_o,
  output cand_t held_o
);

  cand_t held_q;
  cand_t pass_q;
  logic  take;

  // higher score wins; on equal scores the lower index wins
  assign take = cand_i.vld &&
                (!held_q.vld || cand_i.score > held_q.score ||
                 (cand_i.score == held_q.score && cand_i.idx < held_q.idx));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pass_q <= '0;
    end else if (clr_i) begin
      held_q.vld <= 1'b0;
      pass_q.vld <= 1'b0;
    end else if (shift_i) begin
      if (take) begin
        held_q <= cand_i;
        pass_q <= held_q;
      end else begin
        pass_q <= cand_i;
      end
    end
  end

  assign cand_o = pass_q;
  assign held_o = held_q;

endmodule

[rtl/cosine_topk_vector_search.sv]
// Cosine top-k search. Index vectors load one element per start, accepted
// only while idle. The last element of a load vector starts a norm pass
// over the stored vector if its length equals the configured dim and the
// index is not full. The last query element starts a query norm pass and
// then a scan: per stored entry, a dot product and then the shared
// square-root/divide unit, after which the score enters a row of MAX_TOPK
// ranking cells that hand candidates on one cell per step. After the chain
// drains, results come out one per cycle, best first, on out_valid_o for
// exactly one cycle. A query against an empty index gives one status word
// the next cycle. The receiver cannot stall the result stream. busy stays
// high after the last element of a vector until its work is done. The
// vector store is one memory of MAX_ENTRIES*MAX_DIM words with one write
// and one read port.
module cosine_topk_vector_search import ctvs_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned MAX_DIM     = 256,
  parameter int unsigned MAX_TOPK    = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_i,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_index_i,
  input  logic [8:0] cfg_data_i,
  output logic      out_valid_o,
  output out_word_t out_o
);

  localparam int unsigned EW = $clog2(MAX_ENTRIES) > 0 ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned DW = $clog2(MAX_DIM) > 0 ? $clog2(MAX_DIM) : 1;
  localparam int unsigned CW = $clog2(MAX_DIM + 2);
  localparam int unsigned NW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned KW = $clog2(MAX_TOPK + 1);
  localparam int unsigned KIW = $clog2(MAX_TOPK) > 0 ? $clog2(MAX_TOPK) : 1;

  state_e st_q, st_d;

  // configuration
  logic [8:0] dim_q;
  logic [3:0] topk_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q  <= 9'd256;
      topk_q <= 4'd3;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_DIM) dim_q <= cfg_data_i;
      else topk_q <= cfg_data_i[3:0];
    end
  end

  // memories
  logic signed [ElemW-1:0] vstore [MAX_ENTRIES*MAX_DIM];
  logic signed [ElemW-1:0] qbuf   [MAX_DIM];
  logic [AccW-1:0]         enorm  [MAX_ENTRIES];
  logic [CW-1:0]           elen   [MAX_ENTRIES];

  logic [NW-1:0] count_q, count_d;
  logic [CW-1:0] ecnt_q, ecnt_d;
  logic          kind_q, kind_d;
  logic [CW-1:0] qlen_q, qlen_d;
  logic [EW-1:0] ent_q, ent_d;
  logic [CW-1:0] i_q, i_d;
  logic [AccW-1:0] acc_q, acc_d, qn_q, qn_d;
  logic [KW-1:0] k_q, k_d, r_q, r_d;

  logic signed [ElemW-1:0] vrd_q, qrd_q;
  logic [AccW-1:0] en_rd_q;
  logic [CW-1:0]   len_rd_q;
  logic            rd_vld_q, rd_vld_d;
  logic [AccW-1:0] prod_q;
  logic            prod_vld_q;

  logic acc_in;
  assign acc_in = start && !busy;

  logic          vs_we, qb_we;
  logic [EW+DW-1:0] vs_wa, vs_ra;
  logic [DW-1:0] qb_a;
  logic          en_we;

  assign vs_ra = {ent_q, i_q[DW-1:0]};
  always_ff @(posedge clk_i) begin
    if (vs_we) vstore[vs_wa] <= in_i.value;
    vrd_q <= vstore[vs_ra];
    if (qb_we) qbuf[qb_a] <= in_i.value;
    qrd_q <= qbuf[i_q[DW-1:0]];
    if (en_we) begin
      enorm[ent_q] <= acc_q;
      elen[ent_q]  <= qlen_q;
    end
    en_rd_q  <= enorm[ent_q];
    len_rd_q <= elen[ent_q];
  end

  // multiply stage: registered product of the two streamed operands, or a square in the norm passes
  logic signed [31:0] mop;
  always_comb begin
    mop = (st_q == S_DOT) ? vrd_q * qrd_q
        : (st_q == S_QNORM) ? qrd_q * qrd_q : vrd_q * vrd_q;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      rd_vld_q   <= 1'b0;
    end else begin
      prod_vld_q <= rd_vld_q;
      rd_vld_q   <= rd_vld_d;
    end
  end
  always_ff @(posedge clk_i) prod_q <= AccW'($signed(mop));

  // divider
  logic div_start, div_done;
  logic signed [ScoreW-1:0] div_score;
  logic zero_flag;
  assign zero_flag = (qlen_q > CW'(MAX_DIM)) || (qlen_q != len_rd_q);
  ctvs_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .qn_i(qn_q), .en_i(en_rd_q),
    .dot_i(acc_q), .zero_i(zero_flag), .done_o(div_done), .score_o(div_score)
  );

  // ranking chain
  cand_t chain [MAX_TOPK+1];
  cand_t held  [MAX_TOPK];
  logic  ch_clr, ch_shift;
  cand_t feed;
  always_comb begin
    feed.vld   = (st_q == S_DIV) && div_done;
    feed.idx   = 12'(ent_q);
    feed.score = div_score;
    if (st_q == S_OUT) feed.vld = 1'b0;
  end
  assign chain[0] = feed;
  assign ch_shift = (st_q == S_DIV && div_done) || (st_q == S_DRAIN);
  for (genvar g = 0; g < MAX_TOPK; g++) begin : g_cell
    ctvs_cell u_cell (
      .clk_i, .rst_ni, .clr_i(ch_clr), .shift_i(ch_shift),
      .cand_i(chain[g]), .cand_o(chain[g+1]), .held_o(held[g])
    );
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; count_q <= '0; ecnt_q <= '0; kind_q <= 1'b0;
    end else begin
      st_q <= st_d; count_q <= count_d; ecnt_q <= ecnt_d; kind_q <= kind_d;
    end
  end
  always_ff @(posedge clk_i) begin
    qlen_q <= qlen_d; ent_q <= ent_d; i_q <= i_d; acc_q <= acc_d;
    qn_q <= qn_d; k_q <= k_d; r_q <= r_d;
  end

  logic [CW-1:0] ec;
  logic [3:0]    kk;
  always_comb begin
    st_d = st_q; count_d = count_q; ecnt_d = ecnt_q; kind_d = kind_q;
    qlen_d = qlen_q; ent_d = ent_q; i_d = i_q; acc_d = acc_q; qn_d = qn_q;
    k_d = k_q; r_d = r_q;
    vs_we = 1'b0; qb_we = 1'b0; en_we = 1'b0; vs_wa = '0; qb_a = '0;
    rd_vld_d = 1'b0; div_start = 1'b0; ch_clr = 1'b0;
    out_valid_o = 1'b0; out_o = '0; busy = 1'b1;
    ec = ecnt_q; kk = '0;
    case (st_q)
      S_IDLE: begin
        busy = 1'b0;
        if (acc_in) begin
          if (in_i.op == OP_CLEAR) begin
            count_d = '0; ecnt_d = '0;
          end else if (in_i.op != OP_NONE) begin
            if (ecnt_q != '0 && in_i.op[0] != kind_q) ec = '0;
            kind_d = in_i.op[0];
            if (ec < CW'(MAX_DIM)) begin
              if (in_i.op == OP_QUERY) begin
                qb_we = 1'b1; qb_a = ec[DW-1:0];
              end else if (count_q < NW'(MAX_ENTRIES)) begin
                vs_we = 1'b1; vs_wa = {count_q[EW-1:0], ec[DW-1:0]};
              end
            end
            if (ec <= CW'(MAX_DIM)) ec = ec + 1'b1;
            ecnt_d = ec;
            if (in_i.last_of_vector) begin
              ecnt_d = '0;
              qlen_d = ec;
              i_d = '0; acc_d = '0;
              if (in_i.op == OP_LOAD) begin
                if (ec <= CW'(MAX_DIM) && ec == CW'(dim_q)
                    && count_q < NW'(MAX_ENTRIES)) begin
                  ent_d = count_q[EW-1:0];
                  st_d = S_NORM;
                end
              end else if (count_q == '0) begin
                st_d = S_EMPTY;
              end else begin
                kk = (topk_q == 4'd0) ? 4'd1 : topk_q;
                if (32'(kk) > MAX_TOPK) kk = 4'(MAX_TOPK);
                k_d = (32'(kk) > 32'(count_q)) ? KW'(count_q) : KW'(kk);
                st_d = S_QNORM;
              end
            end
          end
        end
      end
      // stream qlen words (at most MAX_DIM), accumulate products after the read and multiply registers
      S_NORM, S_QNORM, S_DOT: begin
        if (i_q < qlen_q && i_q < CW'(MAX_DIM)) begin
          rd_vld_d = 1'b1;
          i_d = i_q + 1'b1;
        end
        if (prod_vld_q) acc_d = acc_q + prod_q;
        if (!rd_vld_d && !rd_vld_q && !prod_vld_q) begin
          i_d = '0;
          if (st_q == S_NORM) begin
            en_we = 1'b1;
            count_d = count_q + 1'b1;
            st_d = S_IDLE;
          end else if (st_q == S_QNORM) begin
            qn_d = (qlen_q <= CW'(MAX_DIM)) ? acc_q : '0;
            acc_d = '0; ent_d = '0; ch_clr = 1'b1;
            st_d = S_DOT;
          end else begin
            div_start = 1'b1;
            st_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          acc_d = '0;
          if (32'(ent_q) + 1 == 32'(count_q)) begin
            r_d = '0; st_d = S_DRAIN; i_d = '0;
          end else begin
            ent_d = ent_q + 1'b1;
            st_d = S_DOT;
          end
        end
      end
      S_DRAIN: begin
        i_d = i_q + 1'b1;
        if (i_q == CW'(MAX_TOPK)) st_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        out_o.entry_index = held[r_q[KIW-1:0]].idx[5:0];
        out_o.score = held[r_q[KIW-1:0]].score;
        out_o.last_result = (r_q + 1'b1 == k_q);
        r_d = r_q + 1'b1;
        if (r_q + 1'b1 == k_q) st_d = S_IDLE;
      end
      S_EMPTY: begin
        out_valid_o = 1'b1;
        out_o.last_result = 1'b1;
        out_o.status = 1'b1;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

endmodule
